// ===== rtl/bounded_delay_shortest_seek_scheduler_macros.svh =====
// Assertion macros for the bounded-delay shortest-seek scheduler.
`ifndef BOUNDED_DELAY_SHORTEST_SEEK_SCHEDULER_MACROS_SVH
`define BOUNDED_DELAY_SHORTEST_SEEK_SCHEDULER_MACROS_SVH

// Invariant checked on every clock outside reset.
`define BDSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define BDSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/bdss_pkg.sv =====
// Shared constants, state encoding and controller/datapath interface types.
package bdss_pkg;

  localparam int MAX_SLACK_DEF    = 15;
  localparam int WINDOW_DEPTH_DEF = 32;
  localparam int TRACK_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF   = 20;
  localparam int MAX_RESULTS      = 16;
  localparam int TOTAL_BITS       = 36;
  localparam int CFG_BITS         = 4;
  localparam int PEND_W           = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SERVE
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic serve;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_decision;
    logic scan_done;
    logic found;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/bdss_ctrl.sv =====
// Controller state machine: request intake, window scan sequencing and result issue.
module bdss_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  bdss_pkg::dp_status_t  status,
  output bdss_pkg::ctrl_cmd_t   cmd
);
  import bdss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.need_decision ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_SERVE;
      end
      ST_SERVE: begin
        if (!status.found) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          state_next = ST_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = (state == ST_IDLE);
    cmd.accept = (state == ST_IDLE) && s_tvalid;
    cmd.start  = (state == ST_CHECK) && status.need_decision;
    cmd.serve  = (state == ST_SERVE) && status.found && status.out_free;
  end

endmodule

// ===== rtl/bdss_dp.sv =====
// Datapath: track window memory, served bits, counters, serial nearest-track scan, result register.
`include "bounded_delay_shortest_seek_scheduler_macros.svh"

module bdss_dp #(
  parameter int MAX_SLACK    = bdss_pkg::MAX_SLACK_DEF,
  parameter int WINDOW_DEPTH = bdss_pkg::WINDOW_DEPTH_DEF,
  parameter int TRACK_BITS   = bdss_pkg::TRACK_BITS_DEF,
  parameter int COUNT_BITS   = bdss_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bdss_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  logic [TRACK_BITS-1:0]             in_track,
  input  logic                              in_last,
  input  bdss_pkg::ctrl_cmd_t               cmd,
  output bdss_pkg::dp_status_t              status,
  input  logic                              m_tready,
  output logic                              out_valid,
  output logic [COUNT_BITS-1:0]             out_req,
  output logic [TRACK_BITS-1:0]             out_trk,
  output logic [TRACK_BITS-1:0]             out_seek,
  output logic [bdss_pkg::TOTAL_BITS-1:0]   out_total,
  output logic                              out_forced,
  output logic                              out_last,
  output logic                              out_done
);
  import bdss_pkg::*;

  localparam int LIM_A     = (MAX_SLACK < (WINDOW_DEPTH - 1) / 2) ? MAX_SLACK
                                                                  : (WINDOW_DEPTH - 1) / 2;
  localparam int SLACK_LIM = (LIM_A < MAX_RESULTS - 1) ? LIM_A : MAX_RESULTS - 1;
  localparam int IDXW      = $clog2(WINDOW_DEPTH);
  localparam int SPAN_W    = PEND_W + 1;
  localparam int SUMW      = TOTAL_BITS + 1;

  function automatic logic [IDXW-1:0] slot_of(input logic [IDXW-1:0] nw,
                                              input logic [IDXW-1:0] bk);
    logic [IDXW:0] wrapped;
    wrapped = {1'b0, nw} + (IDXW + 1)'(WINDOW_DEPTH) - {1'b0, bk};
    return (nw >= bk) ? (nw - bk) : wrapped[IDXW-1:0];
  endfunction

  logic [TRACK_BITS-1:0] mem [WINDOW_DEPTH];
  logic [TRACK_BITS-1:0] mem_q;
  logic [WINDOW_DEPTH-1:0] served;

  logic [CFG_BITS-1:0]   cfg_slack;
  logic [CFG_BITS-1:0]   slack;
  logic [CFG_BITS-1:0]   history;
  logic [PEND_W-1:0]     pending;
  logic [COUNT_BITS-1:0] arrivals;
  logic [IDXW-1:0]       newest;
  logic [TRACK_BITS-1:0] head;
  logic [TOTAL_BITS-1:0] sum;
  logic                  batch_open;
  logic                  last_flag;

  logic                  issuing;
  logic                  forced_mode;
  logic [IDXW-1:0]       idx;
  logic                  rd_pend;
  logic                  rd_ok;
  logic [IDXW-1:0]       rd_back;
  logic [IDXW-1:0]       rd_slot;

  logic                  best_found;
  logic [TRACK_BITS-1:0] best_dist;
  logic [TRACK_BITS-1:0] best_track;
  logic [IDXW-1:0]       best_back;
  logic [IDXW-1:0]       best_slot;

  logic [IDXW-1:0]       newest_next;
  logic [CFG_BITS-1:0]   slack_clamped;
  logic [PEND_W-1:0]     slack_ext;
  logic [PEND_W-1:0]     slack_p1;
  logic [SPAN_W-1:0]     span;
  logic [IDXW-1:0]       oldest_back;
  logic [IDXW-1:0]       oldest_slot;
  logic                  forced_now;
  logic [IDXW-1:0]       scan_slot;
  logic [TRACK_BITS-1:0] rd_dist;
  logic                  take;
  logic [SUMW-1:0]       sum_wide;
  logic [TOTAL_BITS-1:0] sum_new;
  logic [PEND_W-1:0]     pend_after;
  logic                  closing;
  logic                  run_end;

  always_comb begin
    newest_next   = (newest == IDXW'(WINDOW_DEPTH - 1)) ? '0 : newest + IDXW'(1);
    slack_clamped = (cfg_slack > CFG_BITS'(SLACK_LIM)) ? CFG_BITS'(SLACK_LIM) : cfg_slack;
    slack_ext     = PEND_W'(slack);
    slack_p1      = slack_ext + PEND_W'(1);
    span          = SPAN_W'(history) + SPAN_W'(pending);
    oldest_back   = IDXW'(span - SPAN_W'(1));
    oldest_slot   = slot_of(newest, oldest_back);
    forced_now    = (history == slack) && !served[oldest_slot];
    scan_slot     = slot_of(newest, idx);
    rd_dist       = (mem_q >= head) ? (mem_q - head) : (head - mem_q);
    take          = rd_pend && rd_ok && (forced_mode || !best_found || rd_dist < best_dist);
    sum_wide      = SUMW'(sum) + SUMW'(best_dist);
    sum_new       = sum_wide[TOTAL_BITS] ? '1 : sum_wide[TOTAL_BITS-1:0];
    pend_after    = pending - PEND_W'(1);
    closing       = last_flag && (pend_after == '0);
    run_end       = (pend_after == '0) || (!last_flag && pend_after <= slack_ext);

    status.need_decision = (pending != '0) && (last_flag || pending > slack_ext);
    status.scan_done     = !issuing && !rd_pend;
    status.found         = best_found;
    status.out_free      = !out_valid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) mem[newest_next] <= in_track;
    if (issuing) mem_q <= mem[scan_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_slack   <= '0;
      slack       <= '0;
      history     <= '0;
      pending     <= '0;
      arrivals    <= '0;
      newest      <= IDXW'(WINDOW_DEPTH - 1);
      head        <= '0;
      sum         <= '0;
      batch_open  <= 1'b0;
      last_flag   <= 1'b0;
      served      <= '0;
      issuing     <= 1'b0;
      forced_mode <= 1'b0;
      idx         <= '0;
      rd_pend     <= 1'b0;
      best_found  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) cfg_slack <= cfg_wdata;

      if (cmd.accept) begin
        newest              <= newest_next;
        served[newest_next] <= 1'b0;
        arrivals            <= arrivals + COUNT_BITS'(1);
        pending             <= pending + PEND_W'(1);
        last_flag           <= in_last;
        if (!batch_open) begin
          slack      <= slack_clamped;
          batch_open <= 1'b1;
        end
      end

      if (cmd.start) begin
        idx         <= oldest_back;
        forced_mode <= forced_now;
        issuing     <= 1'b1;
        best_found  <= 1'b0;
      end else if (issuing) begin
        if (idx == '0 || forced_mode) begin
          issuing <= 1'b0;
        end else begin
          idx <= idx - IDXW'(1);
        end
      end
      rd_pend <= issuing;

      if (take) best_found <= 1'b1;

      if (cmd.serve) begin
        served[best_slot] <= 1'b1;
        pending           <= pend_after;
        if (closing) begin
          head       <= '0;
          sum        <= '0;
          arrivals   <= '0;
          history    <= '0;
          batch_open <= 1'b0;
        end else begin
          head <= best_track;
          sum  <= sum_new;
          if (history != slack) history <= history + CFG_BITS'(1);
        end
      end

      if (cmd.serve) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      rd_back <= idx;
      rd_slot <= scan_slot;
      rd_ok   <= forced_mode || !served[scan_slot];
    end
    if (take) begin
      best_dist  <= rd_dist;
      best_track <= mem_q;
      best_back  <= rd_back;
      best_slot  <= rd_slot;
    end
    if (cmd.serve) begin
      out_req    <= arrivals - COUNT_BITS'(1) - COUNT_BITS'(best_back);
      out_trk    <= best_track;
      out_seek   <= best_dist;
      out_total  <= sum_new;
      out_forced <= forced_mode;
      out_last   <= run_end;
      out_done   <= closing;
    end
  end

  `BDSS_ASSERT_ALWAYS(a_pending_bound, pending <= slack_p1, "pending exceeds slack plus one")
  `BDSS_ASSERT_ALWAYS(a_history_bound, history <= slack, "history exceeds slack")
  `BDSS_ASSERT_IMP(a_serve_free, cmd.serve, !out_valid || m_tready, "result overwritten")
  `BDSS_ASSERT_IMP(a_done_is_last, out_valid && out_done, out_last, "batch end not run end")

endmodule

// ===== rtl/bounded_delay_shortest_seek_scheduler.sv =====
// Per item: intake, then per decision a check, a serial scan of the window span and an issue.
// Window span is 2*slack+1 once the batch is under way; the batch's last item flushes up to
// 16 decisions the same way. Intake waits for idle, and an issue waits while the output stalls.
// The scan runs serially through the single read port of the track memory.
// Reset (rst, synchronous, active high) clears counters, head, sum, served bits and slack;
// the track memory is not cleared.
module bounded_delay_shortest_seek_scheduler #(
  parameter int MAX_SLACK    = bdss_pkg::MAX_SLACK_DEF,
  parameter int WINDOW_DEPTH = bdss_pkg::WINDOW_DEPTH_DEF,
  parameter int TRACK_BITS   = bdss_pkg::TRACK_BITS_DEF,
  parameter int COUNT_BITS   = bdss_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bdss_pkg::CFG_BITS-1:0]         cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // track
  input  logic [((TRACK_BITS + 7) / 8) * 8-1:0] s_tdata,
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // request_number, served_track, seek_distance, total_distance
  output logic [((COUNT_BITS + 2 * TRACK_BITS + bdss_pkg::TOTAL_BITS + 7) / 8) * 8-1:0] m_tdata,
  output logic                                  m_tlast,
  // forced_pick, batch_done
  output logic [1:0]                            m_tuser
);
  import bdss_pkg::*;

  localparam int OUT_W = ((COUNT_BITS + 2 * TRACK_BITS + TOTAL_BITS + 7) / 8) * 8;

  ctrl_cmd_t             cmd;
  dp_status_t            status;
  logic [COUNT_BITS-1:0] out_req;
  logic [TRACK_BITS-1:0] out_trk;
  logic [TRACK_BITS-1:0] out_seek;
  logic [TOTAL_BITS-1:0] out_total;
  logic                  out_forced;
  logic                  out_last;
  logic                  out_done;

  bdss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bdss_dp #(
    .MAX_SLACK    (MAX_SLACK),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TRACK_BITS   (TRACK_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_track   (s_tdata[TRACK_BITS-1:0]),
    .in_last    (s_tlast),
    .cmd        (cmd),
    .status     (status),
    .m_tready   (m_tready),
    .out_valid  (m_tvalid),
    .out_req    (out_req),
    .out_trk    (out_trk),
    .out_seek   (out_seek),
    .out_total  (out_total),
    .out_forced (out_forced),
    .out_last   (out_last),
    .out_done   (out_done)
  );

  assign m_tdata = OUT_W'({out_total, out_seek, out_trk, out_req});
  assign m_tlast = out_last;
  assign m_tuser = {out_done, out_forced};

endmodule

// ===== tb/bounded_delay_shortest_seek_scheduler_test.sv =====
// Self-checking stream testbench for the bounded-delay shortest-seek request scheduler.
module bounded_delay_shortest_seek_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = bdss_pkg::WINDOW_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 600;
  localparam logic [36:0] TOTAL_MAX = (37'd1 << bdss_pkg::TOTAL_BITS) - 1;

  typedef struct packed {
    logic [15:0] track;
    logic        last;
  } request_t;

  typedef struct packed {
    logic [19:0] req_num;
    logic [15:0] trk;
    logic [15:0] seek;
    logic [35:0] total;
    logic        forced;
    logic        run_last;
    logic        done;
  } service_t;

  typedef enum int {SPREAD, CLUSTER, FEW} track_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  request_t request_q [$];
  service_t service_q [$];
  logic     req_taken = 1'b0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_go = 1'b0;
  logic     holding = 1'b0;
  int       fail_count = 0;

  // scheduler shadow state
  logic [3:0]  slack_cfg = '0;
  logic [15:0] ring_track [WINDOW];
  bit          ring_served [WINDOW];
  logic [15:0] head_pos = '0;
  logic [19:0] arrivals = '0;
  logic [19:0] decisions = '0;
  logic [35:0] seek_total = '0;
  int          newest_slot = WINDOW - 1;
  int          served_hist = 0;
  int          batch_slack = 0;
  bit          batch_open = 1'b0;

  bounded_delay_shortest_seek_scheduler i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  task automatic add_request(input request_t item);
    request_q = {request_q, item};
  endtask

  task automatic clear_batch();
    head_pos = '0;
    arrivals = '0;
    decisions = '0;
    seek_total = '0;
    served_hist = 0;
  endtask

  task automatic schedule_request(input logic [15:0] trk, input logic last);
    service_t    outs [bdss_pkg::MAX_RESULTS];
    logic [19:0] pend;
    logic [36:0] sum_next;
    int          n, span, back, slot, pick_back, pick_slot, gap, best;
    bit          found, forced;
    if (!batch_open) begin
      batch_slack = slack_cfg;
      if (batch_slack > bdss_pkg::MAX_SLACK_DEF) batch_slack = bdss_pkg::MAX_SLACK_DEF;
      if (batch_slack > (WINDOW - 1) / 2) batch_slack = (WINDOW - 1) / 2;
      if (batch_slack > bdss_pkg::MAX_RESULTS - 1) batch_slack = bdss_pkg::MAX_RESULTS - 1;
      clear_batch();
      batch_open = 1'b1;
    end
    newest_slot = (newest_slot + 1) % WINDOW;
    ring_track[newest_slot] = trk;
    ring_served[newest_slot] = 1'b0;
    arrivals = arrivals + 1'b1;
    n = 0;
    while (n < bdss_pkg::MAX_RESULTS) begin
      pend = arrivals - decisions;
      if (pend == 0) break;
      if (!last && int'(pend) <= batch_slack) break;
      span = served_hist + int'(pend);
      if (span > WINDOW) span = WINDOW;
      found = 1'b0;
      forced = 1'b0;
      best = 0;
      pick_back = 0;
      pick_slot = 0;
      back = span - 1;
      slot = (newest_slot + WINDOW - back) % WINDOW;
      if (served_hist == batch_slack && !ring_served[slot]) begin
        forced = 1'b1;
        found = 1'b1;
        pick_back = back;
        pick_slot = slot;
      end else begin
        // oldest first, strict compare keeps the earliest on a tie
        for (back = span - 1; back >= 0; back--) begin
          slot = (newest_slot + WINDOW - back) % WINDOW;
          if (!ring_served[slot]) begin
            gap = (ring_track[slot] >= head_pos) ? ring_track[slot] - head_pos
                                                  : head_pos - ring_track[slot];
            if (!found || gap < best) begin
              found = 1'b1;
              best = gap;
              pick_back = back;
              pick_slot = slot;
            end
          end
        end
      end
      if (!found) break;
      gap = (ring_track[pick_slot] >= head_pos) ? ring_track[pick_slot] - head_pos
                                                 : head_pos - ring_track[pick_slot];
      sum_next = seek_total + gap;
      seek_total = (sum_next > TOTAL_MAX) ? TOTAL_MAX[35:0] : sum_next[35:0];
      outs[n] = {arrivals - 20'd1 - 20'(pick_back), ring_track[pick_slot], 16'(gap),
                 seek_total, forced, 1'b0, 1'b0};
      ring_served[pick_slot] = 1'b1;
      head_pos = ring_track[pick_slot];
      decisions = decisions + 1'b1;
      if (served_hist < batch_slack) served_hist++;
      n++;
    end
    pend = arrivals - decisions;
    if (n > 0) begin
      outs[n - 1].run_last = 1'b1;
      if (last && pend == 0) outs[n - 1].done = 1'b1;
    end
    for (int i = 0; i < n; i++) service_q = {service_q, outs[i]};
    if (last && pend == 0) begin
      batch_open = 1'b0;
      clear_batch();
    end
  endtask

  always @(posedge clk) begin : monitor
    service_t got, want;
    req_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_we) slack_cfg = cfg_wdata;
      if (s_tvalid && s_tready) schedule_request(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = {m_tdata[19:0], m_tdata[35:20], m_tdata[51:36], m_tdata[87:52],
               m_tuser[0], m_tlast, m_tuser[1]};
        if (service_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: number %0d track %0d", got.req_num, got.trk);
        end else begin
          want = service_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch (exp/got): number %0d/%0d track %0d/%0d seek %0d/%0d",
                        " total %0d/%0d forced %0b/%0b last %0b/%0b done %0b/%0b"},
                       want.req_num, got.req_num, want.trk, got.trk, want.seek, got.seek,
                       want.total, got.total, want.forced, got.forced,
                       want.run_last, got.run_last, want.done, got.done);
          end
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    request_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = request_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= req.track;
        s_tlast <= req.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !holding && ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin : hold_off
    wait (hold_go);
    @(negedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [15:0] pick_track(track_style_t style, int center);
    int t;
    case (style)
      SPREAD:  t = $urandom_range(0, 65535);
      CLUSTER: t = center + $urandom_range(0, 512) - 256;
      default: t = center + 100 * $urandom_range(0, 2);
    endcase
    if ($urandom_range(0, 15) == 0) t = $urandom_range(0, 1) ? 65535 : 0;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return 16'(t);
  endfunction

  task automatic push_batch(input int len, input track_style_t style, input bit close);
    int center;
    center = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++)
      add_request({pick_track(style, center), close && i == len - 1});
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || s_tvalid || service_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_slack(input logic [3:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int send_idle_of [4];
    int stall_of [4];
    int len, count;
    track_style_t style;
    send_idle_of = '{0, 79, 0, 21};
    stall_of = '{0, 0, 79, 21};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // slack 0: served strictly in arrival order, extreme tracks
    write_slack(4'd0);
    add_request({16'd0, 1'b0});
    add_request({16'd65535, 1'b0});
    add_request({16'd65535, 1'b0});
    add_request({16'd1, 1'b0});
    add_request({16'd32768, 1'b1});
    add_request({16'd12345, 1'b1});
    wait_drained();

    // max slack, batch shorter than slack, tie on equal distance
    write_slack(4'd15);
    add_request({16'd400, 1'b0});
    add_request({16'd200, 1'b0});
    add_request({16'd200, 1'b0});
    add_request({16'd600, 1'b1});
    wait_drained();

    // slack changed mid batch only applies to the next batch; far track gets forced
    write_slack(4'd3);
    add_request({16'd10, 1'b0});
    add_request({16'd50000, 1'b0});
    add_request({16'd20, 1'b0});
    add_request({16'd30, 1'b0});
    add_request({16'd40, 1'b0});
    wait_drained();
    write_slack(4'd7);
    add_request({16'd65535, 1'b0});
    add_request({16'd0, 1'b0});
    add_request({16'd5, 1'b1});
    push_batch(8, SPREAD, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_idle_of[phase];
      stall_pct = stall_of[phase];
      case (phase)
        0: write_slack(4'd15);
        1: write_slack(4'd0);
        default: write_slack(4'($urandom_range(0, 15)));
      endcase
      if (phase == 0) hold_go = 1'b1;
      // sender pauses mid batch until all results are out
      len = $urandom_range(4, 24);
      push_batch(len / 2, CLUSTER, 1'b0);
      wait_drained();
      push_batch(len - len / 2, CLUSTER, 1'b1);
      count = len;
      while (count < 30) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
        style = track_style_t'($urandom_range(0, 2));
        push_batch(len, style, 1'b1);
        count += len;
      end
      wait_drained();
    end

    fail_count += service_q.size();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
